FILE: src/ccr_pkg.sv
// Shared constants, codes and types of the circle collision resolver.
package ccr_pkg;

	localparam int COORD_BITS = 16;
	localparam int FRAC_BITS  = 4;
	localparam int RAD_BITS   = 12;
	localparam int SUM_BITS   = RAD_BITS + 1;
	localparam int WIDE_BITS  = COORD_BITS + SUM_BITS;
	localparam int WALL_GAP   = 5 << FRAC_BITS;
	localparam int EXT_BITS   = 16;
	localparam int D2_BITS    = 2 * SUM_BITS + 1;
	localparam int ROOT_BITS  = (D2_BITS + EXT_BITS + 1) / 2;
	localparam int SQ_BITS    = 2 * ROOT_BITS;
	localparam int PROD_BITS  = SUM_BITS + ROOT_BITS;
	localparam int NUM_BITS   = PROD_BITS + 2;
	localparam int DEN_BITS   = ROOT_BITS + 1;
	localparam int QUO_BITS   = SUM_BITS + 1;
	localparam int IDX_BITS   = 1;

	localparam logic [COORD_BITS-1:0] COORD_MAX = {COORD_BITS{1'b1}};
	localparam logic [15:0] ARENA_W_RESET = 16'd16384;
	localparam logic [15:0] ARENA_H_RESET = 16'd12288;

	typedef enum logic [IDX_BITS-1:0] {
		REG_ARENA_W = 1'b0,
		REG_ARENA_H = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		WALL_NONE   = 3'd0,
		WALL_RIGHT  = 3'd1,
		WALL_LEFT   = 3'd2,
		WALL_BOTTOM = 3'd3,
		WALL_TOP    = 3'd4
	} wall_code_t;

	typedef struct packed {
		logic                  cmd;
		logic [COORD_BITS-1:0] mx;
		logic [COORD_BITS-1:0] my;
		logic                  whit;
		wall_code_t            wcode;
		logic [COORD_BITS-1:0] wx;
		logic [COORD_BITS-1:0] wy;
		logic                  sx;
		logic                  sy;
		logic [SUM_BITS-1:0]   ax;
		logic [SUM_BITS-1:0]   ay;
		logic [SUM_BITS-1:0]   s;
		logic                  rng;
		logic                  phit;
		logic                  zero;
	} pl_t;

	typedef struct packed {
		logic                  hit;
		wall_code_t            code;
		logic [COORD_BITS-1:0] nx;
		logic [COORD_BITS-1:0] ny;
	} res_t;

endpackage

FILE: src/ccr_in_if.sv
// Input item channel of the circle collision resolver.
interface ccr_in_if;
	logic                           valid;
	logic                           ready;
	logic                           cmd;
	logic [ccr_pkg::COORD_BITS-1:0] mob_x;
	logic [ccr_pkg::COORD_BITS-1:0] mob_y;
	logic [ccr_pkg::RAD_BITS-1:0]   mob_radius;
	logic [ccr_pkg::COORD_BITS-1:0] oth_x;
	logic [ccr_pkg::COORD_BITS-1:0] oth_y;
	logic [ccr_pkg::RAD_BITS-1:0]   oth_radius;

	modport source (output valid, cmd, mob_x, mob_y, mob_radius, oth_x, oth_y, oth_radius,
		input ready);
	modport sink (input valid, cmd, mob_x, mob_y, mob_radius, oth_x, oth_y, oth_radius,
		output ready);
endinterface

FILE: src/ccr_out_if.sv
// Result item channel of the circle collision resolver.
interface ccr_out_if;
	logic                           valid;
	logic                           ready;
	logic                           hit;
	logic [2:0]                     wall_code;
	logic [ccr_pkg::COORD_BITS-1:0] new_x;
	logic [ccr_pkg::COORD_BITS-1:0] new_y;

	modport source (output valid, hit, wall_code, new_x, new_y, input ready);
	modport sink (input valid, hit, wall_code, new_x, new_y, output ready);
endinterface

FILE: src/ccr_cfg_if.sv
// Register write channel of the circle collision resolver.
interface ccr_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [ccr_pkg::IDX_BITS-1:0]   index;
	logic [ccr_pkg::COORD_BITS-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: src/circle_collision_resolver_core.sv
// Top level of the circle collision resolver: wall and circle pair tests in a deep pipeline.
//
//   channel  direction  carries
//   cfg      in         index, data (arena width, arena height)
//   req      in         cmd, mob_x, mob_y, mob_radius, oth_x, oth_y, oth_radius
//   rsp      out        hit, wall_code, new_x, new_y
//
// One item enters per cycle while the skid stage is empty; each result passes the front stages,
// the bit-per-stage square root and divider, and the output register.
// Reset clears all valid bits and loads the arena registers with their reset values.
// An output register with a skid stage behind it holds results; the pipeline stalls
// as a whole only while the skid stage is full, and then no transfer is lost.
module circle_collision_resolver_core (
	input  logic      clk,
	input  logic      arst_n,
	ccr_cfg_if.sink   cfg,
	ccr_in_if.sink    req,
	ccr_out_if.source rsp
);
	import ccr_pkg::*;

	localparam int C  = COORD_BITS;
	localparam int W  = WIDE_BITS;
	localparam int RB = ROOT_BITS;
	localparam int QB = QUO_BITS;

	logic [C-1:0] arena_w_q, arena_h_q;
	logic         en;

	logic                cmd_s1;
	logic [C-1:0]        mx_s1, my_s1, ox_s1, oy_s1;
	logic [RAD_BITS-1:0] mr_s1, or_s1;
	logic                v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	pl_t                 pl_s2, pl_s3, pl_s4, pl_s5, pl_s6, pl_s7;
	pl_t                 pl_n2, pl_n4;
	logic [2*SUM_BITS-1:0] ax2_s3, ay2_s3, ssq_s3;
	logic [D2_BITS-1:0]  d2_n;
	logic [D2_BITS-1:0]  d2_s4;
	logic [RB-1:0]       q_root;
	logic                v_sqrt_s [RB];
	pl_t                 pl_sqrt_s [RB];
	logic [RB-1:0]       q_s5, q_s6, sf_n;
	logic [RB-1:0]       m_s5;
	logic [PROD_BITS-1:0] px_s6, py_s6;
	logic [NUM_BITS-1:0] numx_s7, numy_s7;
	logic [DEN_BITS-1:0] den_s7;
	logic [QB-1:0]       offx, offy;
	logic                v_div_s [QB];
	pl_t                 pl_div_s [QB];
	pl_t                 plf;
	res_t                res_n, out_q, skid_q;
	logic                out_v_q, skid_v_q, push, pop;

	// Register writes.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arena_w_q <= C'(ARENA_W_RESET);
			arena_h_q <= C'(ARENA_H_RESET);
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_ARENA_W: arena_w_q <= cfg.data;
				REG_ARENA_H: arena_h_q <= cfg.data;
				default: ;
			endcase
		end
	end

	assign en        = !skid_v_q;
	assign req.ready = en;

	// Wall tests and pair deltas from the captured item.
	logic [W-1:0] inset, r_w, left_x, wr_x, wb_y;
	logic [C-1:0] adx, ady;

	always_comb begin
		r_w   = W'(mr_s1);
		inset = r_w + W'(WALL_GAP);
		left_x = (inset > W'(COORD_MAX)) ? W'(COORD_MAX) : inset;
		wr_x  = (W'(arena_w_q) >= inset) ? W'(arena_w_q) - inset : '0;
		wb_y  = (W'(arena_h_q) >= inset) ? W'(arena_h_q) - inset : '0;
		pl_n2       = '0;
		pl_n2.cmd   = cmd_s1;
		pl_n2.mx    = mx_s1;
		pl_n2.my    = my_s1;
		pl_n2.wx    = mx_s1;
		pl_n2.wy    = my_s1;
		pl_n2.wcode = WALL_NONE;
		priority if (W'(mx_s1) + r_w >= W'(arena_w_q)) begin
			pl_n2.whit  = 1'b1;
			pl_n2.wcode = WALL_RIGHT;
			pl_n2.wx    = C'(wr_x);
		end else if (W'(mx_s1) <= r_w) begin
			pl_n2.whit  = 1'b1;
			pl_n2.wcode = WALL_LEFT;
			pl_n2.wx    = C'(left_x);
		end else if (W'(my_s1) + r_w >= W'(arena_h_q)) begin
			pl_n2.whit  = 1'b1;
			pl_n2.wcode = WALL_BOTTOM;
			pl_n2.wy    = C'(wb_y);
		end else if (W'(my_s1) <= r_w) begin
			pl_n2.whit  = 1'b1;
			pl_n2.wcode = WALL_TOP;
			pl_n2.wy    = C'(left_x);
		end else begin
			pl_n2.whit  = 1'b0;
		end
		pl_n2.sx  = mx_s1 >= ox_s1;
		pl_n2.sy  = my_s1 >= oy_s1;
		adx       = pl_n2.sx ? mx_s1 - ox_s1 : ox_s1 - mx_s1;
		ady       = pl_n2.sy ? my_s1 - oy_s1 : oy_s1 - my_s1;
		pl_n2.s   = SUM_BITS'(mr_s1) + SUM_BITS'(or_s1);
		pl_n2.rng = (W'(adx) <= W'(pl_n2.s)) && (W'(ady) <= W'(pl_n2.s));
		pl_n2.ax  = pl_n2.rng ? SUM_BITS'(adx) : '0;
		pl_n2.ay  = pl_n2.rng ? SUM_BITS'(ady) : '0;
	end

	always_comb begin
		d2_n       = D2_BITS'(ax2_s3) + D2_BITS'(ay2_s3);
		pl_n4      = pl_s3;
		pl_n4.phit = pl_s3.cmd && pl_s3.rng && (d2_n <= D2_BITS'(ssq_s3));
		pl_n4.zero = d2_n == '0;
	end

	assign sf_n = RB'(pl_sqrt_s[RB-1].s) << 8;

	// Front stages.
	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1 <= req.cmd;
			mx_s1  <= req.mob_x;
			my_s1  <= req.mob_y;
			mr_s1  <= req.mob_radius;
			ox_s1  <= req.oth_x;
			oy_s1  <= req.oth_y;
			or_s1  <= req.oth_radius;
			pl_s2  <= pl_n2;
			ax2_s3 <= (2*SUM_BITS)'(pl_s2.ax) * (2*SUM_BITS)'(pl_s2.ax);
			ay2_s3 <= (2*SUM_BITS)'(pl_s2.ay) * (2*SUM_BITS)'(pl_s2.ay);
			ssq_s3 <= (2*SUM_BITS)'(pl_s2.s) * (2*SUM_BITS)'(pl_s2.s);
			pl_s3  <= pl_s2;
			d2_s4  <= d2_n;
			pl_s4  <= pl_n4;
			for (int k = 0; k < RB; k++) begin
				pl_sqrt_s[k] <= (k == 0) ? pl_s4 : pl_sqrt_s[(k == 0) ? 0 : k-1];
			end
			q_s5    <= q_root;
			m_s5    <= (sf_n > q_root) ? sf_n - q_root : '0;
			pl_s5   <= pl_sqrt_s[RB-1];
			px_s6   <= PROD_BITS'(pl_s5.ax) * PROD_BITS'(m_s5);
			py_s6   <= PROD_BITS'(pl_s5.ay) * PROD_BITS'(m_s5);
			q_s6    <= q_s5;
			pl_s6   <= pl_s5;
			numx_s7 <= (NUM_BITS'(px_s6) << 1) + NUM_BITS'(q_s6);
			numy_s7 <= (NUM_BITS'(py_s6) << 1) + NUM_BITS'(q_s6);
			den_s7  <= DEN_BITS'(q_s6) << 1;
			pl_s7   <= pl_s6;
			for (int k = 0; k < QB; k++) begin
				pl_div_s[k] <= (k == 0) ? pl_s7 : pl_div_s[(k == 0) ? 0 : k-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			for (int k = 0; k < RB; k++) v_sqrt_s[k] <= 1'b0;
			for (int k = 0; k < QB; k++) v_div_s[k] <= 1'b0;
		end else if (en) begin
			v_s1 <= req.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			for (int k = 0; k < RB; k++) begin
				v_sqrt_s[k] <= (k == 0) ? v_s4 : v_sqrt_s[(k == 0) ? 0 : k-1];
			end
			v_s5 <= v_sqrt_s[RB-1];
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			for (int k = 0; k < QB; k++) begin
				v_div_s[k] <= (k == 0) ? v_s7 : v_div_s[(k == 0) ? 0 : k-1];
			end
		end
	end

	ccr_sqrt u_sqrt (
		.clk  (clk),
		.en   (en),
		.rad  (SQ_BITS'({d2_s4, {EXT_BITS{1'b0}}})),
		.root (q_root)
	);

	ccr_div u_div_x (
		.clk (clk),
		.en  (en),
		.num (numx_s7),
		.den (den_s7),
		.quo (offx)
	);

	ccr_div u_div_y (
		.clk (clk),
		.en  (en),
		.num (numy_s7),
		.den (den_s7),
		.quo (offy)
	);

	// Apply the push and select the result.
	logic [W-1:0] sum_x, sum_y, sum_z;

	assign plf = pl_div_s[QB-1];

	always_comb begin
		sum_x = W'(plf.mx) + W'(offx);
		sum_y = W'(plf.my) + W'(offy);
		sum_z = W'(plf.mx) + W'(plf.s);
		res_n = '{hit: 1'b0, code: WALL_NONE, nx: plf.mx, ny: plf.my};
		if (!plf.cmd) begin
			res_n.hit  = plf.whit;
			res_n.code = plf.wcode;
			res_n.nx   = plf.wx;
			res_n.ny   = plf.wy;
		end else if (plf.phit) begin
			res_n.hit = 1'b1;
			if (plf.zero) begin
				res_n.nx = (sum_z > W'(COORD_MAX)) ? COORD_MAX : C'(sum_z);
			end else begin
				if (plf.sx) begin
					res_n.nx = (sum_x > W'(COORD_MAX)) ? COORD_MAX : C'(sum_x);
				end else begin
					res_n.nx = (W'(plf.mx) >= W'(offx)) ? C'(W'(plf.mx) - W'(offx)) : '0;
				end
				if (plf.sy) begin
					res_n.ny = (sum_y > W'(COORD_MAX)) ? COORD_MAX : C'(sum_y);
				end else begin
					res_n.ny = (W'(plf.my) >= W'(offy)) ? C'(W'(plf.my) - W'(offy)) : '0;
				end
			end
		end
	end

	// Output register and skid stage.
	assign push = en && v_div_s[QB-1];
	assign pop  = out_v_q && rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || pop) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= push;
			end
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || pop) begin
			out_q <= skid_v_q ? skid_q : res_n;
		end else if (push) begin
			skid_q <= res_n;
		end
	end

	assign rsp.valid     = out_v_q;
	assign rsp.hit       = out_q.hit;
	assign rsp.wall_code = out_q.code;
	assign rsp.new_x     = out_q.nx;
	assign rsp.new_y     = out_q.ny;

`ifndef ASSERT_OFF
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("Skid stage holds a result while the output register is empty.");

	a_skid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q && !rsp.ready |=> skid_v_q)
		else $error("Skid stage dropped a result without a transfer.");

	a_code_means_hit: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.wall_code != WALL_NONE) |-> rsp.hit)
		else $error("Wall code given without a hit.");

	a_stall_freezes_front: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(v_s7) && $stable(v_div_s[QB-1]))
		else $error("Pipeline moved while stalled.");
`endif
endmodule

FILE: src/ccr_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module ccr_sqrt (
	input  logic                          clk,
	input  logic                          en,
	input  logic [ccr_pkg::SQ_BITS-1:0]   rad,
	output logic [ccr_pkg::ROOT_BITS-1:0] root
);
	import ccr_pkg::*;

	localparam int RB = ROOT_BITS;
	localparam int RW = ROOT_BITS + 1;

	logic [RW-1:0]      rem_q  [RB];
	logic [RB-1:0]      root_q [RB];
	logic [SQ_BITS-1:0] rad_q  [RB];
	logic [RW-1:0]      rem_p  [RB];
	logic [RB-1:0]      root_p [RB];
	logic [SQ_BITS-1:0] rad_p  [RB];
	logic [RW+1:0]      rem_t  [RB];
	logic [RW+1:0]      trial  [RB];
	logic               ge     [RB];
	logic [RW-1:0]      rem_n  [RB];
	logic [RB-1:0]      root_n [RB];
	logic [SQ_BITS-1:0] rad_n  [RB];

	always_comb begin
		for (int k = 0; k < RB; k++) begin
			if (k == 0) begin
				rem_p[k]  = '0;
				root_p[k] = '0;
				rad_p[k]  = rad;
			end else begin
				rem_p[k]  = rem_q[k-1];
				root_p[k] = root_q[k-1];
				rad_p[k]  = rad_q[k-1];
			end
			rem_t[k]  = {rem_p[k], rad_p[k][SQ_BITS-1 -: 2]};
			trial[k]  = (RW+2)'({root_p[k], 2'b01});
			ge[k]     = rem_t[k] >= trial[k];
			rem_n[k]  = ge[k] ? RW'(rem_t[k] - trial[k]) : RW'(rem_t[k]);
			root_n[k] = {root_p[k][RB-2:0], ge[k]};
			rad_n[k]  = rad_p[k] << 2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < RB; k++) begin
				rem_q[k]  <= rem_n[k];
				root_q[k] <= root_n[k];
				rad_q[k]  <= rad_n[k];
			end
		end
	end

	assign root = root_q[RB-1];
endmodule

FILE: src/ccr_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module ccr_div (
	input  logic                         clk,
	input  logic                         en,
	input  logic [ccr_pkg::NUM_BITS-1:0] num,
	input  logic [ccr_pkg::DEN_BITS-1:0] den,
	output logic [ccr_pkg::QUO_BITS-1:0] quo
);
	import ccr_pkg::*;

	localparam int QB = QUO_BITS;
	localparam int RW = DEN_BITS + 1;

	logic [RW-1:0]       rem_q [QB];
	logic [QB-1:0]       lo_q  [QB];
	logic [QB-1:0]       quo_q [QB];
	logic [DEN_BITS-1:0] den_q [QB];
	logic [RW-1:0]       rem_p [QB];
	logic [QB-1:0]       lo_p  [QB];
	logic [QB-1:0]       quo_p [QB];
	logic [DEN_BITS-1:0] den_p [QB];
	logic [RW:0]         r_t   [QB];
	logic                ge    [QB];
	logic [RW-1:0]       rem_n [QB];

	always_comb begin
		for (int k = 0; k < QB; k++) begin
			if (k == 0) begin
				rem_p[k] = RW'(num >> QB);
				lo_p[k]  = num[QB-1:0];
				quo_p[k] = '0;
				den_p[k] = den;
			end else begin
				rem_p[k] = rem_q[k-1];
				lo_p[k]  = lo_q[k-1];
				quo_p[k] = quo_q[k-1];
				den_p[k] = den_q[k-1];
			end
			r_t[k]   = {rem_p[k], lo_p[k][QB-1]};
			ge[k]    = r_t[k] >= (RW+1)'(den_p[k]);
			rem_n[k] = ge[k] ? RW'(r_t[k] - (RW+1)'(den_p[k])) : RW'(r_t[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < QB; k++) begin
				rem_q[k] <= rem_n[k];
				lo_q[k]  <= lo_p[k] << 1;
				quo_q[k] <= {quo_p[k][QB-2:0], ge[k]};
				den_q[k] <= den_p[k];
			end
		end
	end

	assign quo = quo_q[QB-1];
endmodule

FILE: test/ccr_tb_if.sv
// Note: the interfaces live with the RTL sources; this file holds the testbench item types.
`timescale 1ns / 100ps
package ccr_tb_pkg;
	import ccr_pkg::*;

	typedef struct {
		logic                  cmd;
		logic [COORD_BITS-1:0] mob_x;
		logic [COORD_BITS-1:0] mob_y;
		logic [RAD_BITS-1:0]   mob_radius;
		logic [COORD_BITS-1:0] oth_x;
		logic [COORD_BITS-1:0] oth_y;
		logic [RAD_BITS-1:0]   oth_radius;
	} circle_req_t;

	typedef struct {
		logic                  hit;
		wall_code_t            code;
		logic [COORD_BITS-1:0] nx;
		logic [COORD_BITS-1:0] ny;
	} resolved_t;
endpackage

FILE: test/tb_top.sv
// Self-checking testbench of the circle collision resolver with randomised stimulus and stalls.
`timescale 1ns / 100ps
module tb_top;
	import ccr_pkg::*;
	import ccr_tb_pkg::*;

	localparam int LATENCY = 7 + ROOT_BITS + QUO_BITS;
	localparam longint CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	ccr_cfg_if cfg ();
	ccr_in_if  req ();
	ccr_out_if rsp ();

	circle_collision_resolver_core dut (.clk(clk), .arst_n(arst_n), .cfg(cfg), .req(req),
		.rsp(rsp));

	always #5 clk = ~clk;

	logic [COORD_BITS-1:0] arena_w = ARENA_W_RESET;
	logic [COORD_BITS-1:0] arena_h = ARENA_H_RESET;
	circle_req_t pending_reqs[$];
	resolved_t   expected_res[$];
	int          errors = 0;
	longint      cycles = 0;
	bit          hold_reqs = 1'b0;
	bit          req_taken = 1'b0;
	int          req_gap = 0;
	int          rsp_gap = 0;

	function automatic logic [COORD_BITS-1:0] clamp_coord(longint v);
		if (v < 0) return '0;
		if (v > longint'(COORD_MAX)) return COORD_MAX;
		return v[COORD_BITS-1:0];
	endfunction

	function automatic longint int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint push_along(longint d, longint unsigned m, longint unsigned q);
		longint unsigned mag, off;
		mag = d < 0 ? -d : d;
		off = (mag * m * 2 + q) / (2 * q);
		return d < 0 ? -longint'(off) : longint'(off);
	endfunction

	function automatic resolved_t resolve(circle_req_t c);
		resolved_t r;
		longint inset, dx, dy;
		longint unsigned s, ax, ay, d2, q, m;
		r.hit = 1'b0;
		r.code = WALL_NONE;
		r.nx = c.mob_x;
		r.ny = c.mob_y;
		if (!c.cmd) begin
			inset = longint'(c.mob_radius) + WALL_GAP;
			if (longint'(c.mob_x) + c.mob_radius >= arena_w) begin
				r.hit = 1'b1; r.code = WALL_RIGHT;
				r.nx = clamp_coord(longint'(arena_w) - inset);
			end else if (c.mob_x <= c.mob_radius) begin
				r.hit = 1'b1; r.code = WALL_LEFT;
				r.nx = clamp_coord(inset);
			end else if (longint'(c.mob_y) + c.mob_radius >= arena_h) begin
				r.hit = 1'b1; r.code = WALL_BOTTOM;
				r.ny = clamp_coord(longint'(arena_h) - inset);
			end else if (c.mob_y <= c.mob_radius) begin
				r.hit = 1'b1; r.code = WALL_TOP;
				r.ny = clamp_coord(inset);
			end
		end else begin
			dx = longint'(c.mob_x) - longint'(c.oth_x);
			dy = longint'(c.mob_y) - longint'(c.oth_y);
			s = longint'(c.mob_radius) + c.oth_radius;
			ax = dx < 0 ? -dx : dx;
			ay = dy < 0 ? -dy : dy;
			if (ax <= s && ay <= s) begin
				d2 = ax * ax + ay * ay;
				if (d2 <= s * s) begin
					r.hit = 1'b1;
					if (d2 == 0) begin
						r.nx = clamp_coord(longint'(c.mob_x) + longint'(s));
					end else begin
						q = int_sqrt(d2 << 16);
						m = (s << 8) > q ? (s << 8) - q : 0;
						r.nx = clamp_coord(longint'(c.mob_x) + push_along(dx, m, q));
						r.ny = clamp_coord(longint'(c.mob_y) + push_along(dy, m, q));
					end
				end
			end
		end
		return r;
	endfunction

	task automatic queue_req(int cmd, int mx, int my, int mr, int ox, int oy, int orad);
		circle_req_t c;
		c.cmd = 1'(cmd); c.mob_x = COORD_BITS'(mx); c.mob_y = COORD_BITS'(my);
		c.mob_radius = RAD_BITS'(mr);
		c.oth_x = COORD_BITS'(ox); c.oth_y = COORD_BITS'(oy); c.oth_radius = RAD_BITS'(orad);
		pending_reqs.insert(pending_reqs.size(), c);
	endtask

	function automatic circle_req_t random_req();
		circle_req_t c;
		int k, s;
		k = $urandom_range(0, 9);
		c.cmd = 1'($urandom_range(0, 1));
		c.mob_x = COORD_BITS'($urandom); c.mob_y = COORD_BITS'($urandom);
		c.mob_radius = (k < 2) ? RAD_BITS'($urandom) : RAD_BITS'($urandom_range(0, 400));
		c.oth_x = COORD_BITS'($urandom); c.oth_y = COORD_BITS'($urandom);
		c.oth_radius = (k < 2) ? RAD_BITS'($urandom) : RAD_BITS'($urandom_range(0, 400));
		if (c.cmd && k < 8) begin
			s = c.mob_radius + c.oth_radius + 2;
			c.oth_x = clamp_coord(longint'(c.mob_x) + $urandom_range(0, 2 * s) - s);
			c.oth_y = clamp_coord(longint'(c.mob_y) + $urandom_range(0, 2 * s) - s);
			if (k == 0) begin
				c.oth_x = c.mob_x; c.oth_y = c.mob_y;
			end
		end else if (!c.cmd && k >= 4) begin
			c.mob_x = COORD_BITS'($urandom_range(0, arena_w + 600));
			c.mob_y = COORD_BITS'($urandom_range(0, arena_h + 600));
		end
		return c;
	endfunction

	task automatic wait_drained();
		while (pending_reqs.size() != 0 || expected_res.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [COORD_BITS-1:0] val);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= val;
		do @(posedge clk); while (!cfg.ready);
		if (idx == REG_ARENA_W) arena_w = val;
		else arena_h = val;
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	always @(negedge clk) begin
		if (!req.valid || req_taken) begin
			if (req_gap > 0) begin
				req_gap   <= req_gap - 1;
				req.valid <= 1'b0;
			end else if (!hold_reqs && pending_reqs.size() != 0) begin
				req.valid      <= 1'b1;
				req.cmd        <= pending_reqs[0].cmd;
				req.mob_x      <= pending_reqs[0].mob_x;
				req.mob_y      <= pending_reqs[0].mob_y;
				req.mob_radius <= pending_reqs[0].mob_radius;
				req.oth_x      <= pending_reqs[0].oth_x;
				req.oth_y      <= pending_reqs[0].oth_y;
				req.oth_radius <= pending_reqs[0].oth_radius;
			end else begin
				req.valid <= 1'b0;
			end
		end
		req_taken <= 1'b0;
		if (rsp_gap > 0) begin
			rsp_gap <= rsp_gap - 1;
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		circle_req_t c;
		resolved_t e;
		cycles <= cycles + 1;
		if (arst_n && req.valid && req.ready) begin
			c = pending_reqs.pop_front();
			expected_res.insert(expected_res.size(), resolve(c));
			req_taken <= 1'b1;
			req_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
		end
		if (arst_n && rsp.valid && rsp.ready) begin
			rsp_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
			if (expected_res.size() == 0) begin
				$error("Unexpected result transfer");
				errors++;
			end else begin
				e = expected_res.pop_front();
				if (rsp.hit !== e.hit) begin
					$error("hit: expected %0d, actual %0d", e.hit, rsp.hit); errors++;
				end
				if (rsp.wall_code !== e.code) begin
					$error("wall_code: expected %0d, actual %0d", e.code, rsp.wall_code);
					errors++;
				end
				if (rsp.new_x !== e.nx) begin
					$error("new_x: expected %0d, actual %0d", e.nx, rsp.new_x); errors++;
				end
				if (rsp.new_y !== e.ny) begin
					$error("new_y: expected %0d, actual %0d", e.ny, rsp.new_y); errors++;
				end
			end
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		req.valid = 1'b0; req.cmd = 1'b0; req.mob_x = '0; req.mob_y = '0;
		req.mob_radius = '0; req.oth_x = '0; req.oth_y = '0; req.oth_radius = '0;
		rsp.ready = 1'b0;
		cfg.valid = 1'b0; cfg.index = REG_ARENA_W; cfg.data = '0;
	end

	initial begin
		int phase, n;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		// Directed cases at the reset arena size.
		queue_req(0, 8000, 6000, 100, 0, 0, 0);
		queue_req(0, 16300, 6000, 100, 0, 0, 0);
		queue_req(0, 50, 6000, 100, 0, 0, 0);
		queue_req(0, 8000, 12200, 100, 0, 0, 0);
		queue_req(0, 8000, 100, 100, 0, 0, 0);
		queue_req(0, 65535, 65535, 4095, 65535, 65535, 4095);
		queue_req(0, 0, 0, 0, 0, 0, 0);
		queue_req(0, 4095, 4095, 4095, 0, 0, 0);
		queue_req(1, 1000, 1000, 50, 1000, 1000, 50);
		queue_req(1, 1000, 1000, 0, 1000, 1000, 0);
		queue_req(1, 1000, 1000, 50, 1100, 1000, 50);
		queue_req(1, 1000, 1000, 50, 1101, 1000, 50);
		queue_req(1, 1000, 1000, 50, 1030, 1040, 50);
		queue_req(1, 0, 0, 4095, 4000, 4000, 4095);
		queue_req(1, 65535, 65535, 4095, 65000, 65000, 4095);
		queue_req(1, 65535, 0, 4095, 65535, 0, 4095);
		queue_req(1, 65535, 65535, 0, 0, 0, 0);
		wait_drained();
		write_reg(REG_ARENA_W, 16'd0);
		write_reg(REG_ARENA_H, 16'd65535);
		queue_req(0, 0, 30000, 10, 0, 0, 0);
		queue_req(0, 65535, 65535, 4095, 0, 0, 0);
		wait_drained();
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					write_reg(REG_ARENA_W, 16'd65535); write_reg(REG_ARENA_H, 16'd0);
				end
				1: begin
					write_reg(REG_ARENA_W, 16'd4000); write_reg(REG_ARENA_H, 16'd3000);
				end
				2: begin
					write_reg(REG_ARENA_W, COORD_BITS'($urandom));
					write_reg(REG_ARENA_H, COORD_BITS'($urandom));
				end
				default: begin
					write_reg(REG_ARENA_W, ARENA_W_RESET); write_reg(REG_ARENA_H, ARENA_H_RESET);
				end
			endcase
			for (n = 0; n < 470; n++) pending_reqs.insert(pending_reqs.size(), random_req());
			if (phase == 1) begin
				while (pending_reqs.size() > 235) @(posedge clk);
				hold_reqs = 1'b1;
				while (expected_res.size() != 0 || req.valid) @(posedge clk);
				hold_reqs = 1'b0;
			end
			wait_drained();
		end
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule
